### rtl/core/kmps_pkg.sv
// Shared constants and types of the multi-pattern KMP search core.
package kmps_pkg;

    // Pattern set geometry
    localparam int NUM_PAT     = 4;
    localparam int MAX_LEN     = 8;
    localparam int PAT_W       = 8 * MAX_LEN;
    localparam int LEN_W       = 4;
    localparam int IDX_W       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int PAT_IDX_W   = (NUM_PAT > 1) ? $clog2(NUM_PAT) : 1;
    localparam int LENS_W      = 16;
    localparam int OFS_W       = 32;

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    // Register indexes: patterns sit at 0 .. NUM_PAT-1, lengths right after
    localparam logic [CFG_IDX_W-1:0] CFG_LENS = CFG_IDX_W'(NUM_PAT);

    typedef logic [LEN_W-1:0] t_len;

    // Command from the sequencer to one pattern lane
    typedef struct packed {
        logic       build;
        logic       step;
        logic       clr;
        logic [7:0] text;
    } t_lane_cmd;

    // Status from one pattern lane
    typedef struct packed {
        logic busy;
        logic hit;
    } t_lane_stat;

endpackage

### rtl/core/multi_pattern_kmp_search_core.sv
// Top level of the multi-pattern KMP search core: registers, sequencer, result stage.
//
// Each text word is accepted and then takes one step per failure-link hop plus one
// final compare in every enabled pattern lane (lanes run side by side, none when
// every pattern is disabled), and then loads the result register. Input stall
// stays high for the whole time. A write to any pattern or length register
// starts a rebuild of the failure links on each lane's single byte comparator.
// The input stays stalled until every lane has finished its rebuild. A result
// waiting in the output register does not block the next word; only the word
// after it waits until that result is taken.
module multi_pattern_kmp_search_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [kmps_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [kmps_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [7:0]                           i_text_byte,
    input  logic                                 i_start_req,
    input  logic                                 i_last,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_done_res,
    output logic                                 o_found,
    output logic [kmps_pkg::PAT_IDX_W-1:0]       o_pattern_index,
    output logic [kmps_pkg::OFS_W-1:0]           o_match_start
);
    import kmps_pkg::*;

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_BGO   = 2'd1;
    localparam logic [1:0] T_BWAIT = 2'd2;
    localparam logic [1:0] T_RUN   = 2'd3;

    logic [PAT_W-1:0]     r_pat [NUM_PAT];
    logic [LENS_W-1:0]    r_lens;
    logic [1:0]           r_state;
    logic [OFS_W-1:0]     r_bytes;
    logic                 r_last;
    logic                 r_out_valid;
    logic                 r_out_done;
    logic                 r_out_found;
    logic [PAT_IDX_W-1:0] r_out_idx;
    logic [OFS_W-1:0]     r_out_start;

    t_len                 w_len  [NUM_PAT];
    t_lane_stat           w_stat [NUM_PAT];
    t_lane_cmd            w_cmd;
    logic                 w_in_acc;
    logic                 w_cfg_ok;
    logic                 w_busy_any;
    logic                 w_finish;
    logic                 w_found;
    logic                 w_done;
    logic [PAT_IDX_W-1:0] w_hit_idx;
    t_len                 w_hit_len;
    logic [OFS_W-1:0]     w_start;

    // Saturate the lengths and pick the lowest completed lane
    always_comb begin
        w_busy_any = 1'b0;
        w_found    = 1'b0;
        w_hit_idx  = '0;
        w_hit_len  = '0;
        for (int p = 0; p < NUM_PAT; p++) begin
            w_len[p] = (r_lens[4*p +: 4] > LEN_W'(MAX_LEN)) ?
                       LEN_W'(MAX_LEN) : r_lens[4*p +: 4];
        end
        for (int p = NUM_PAT - 1; p >= 0; p--) begin
            w_busy_any = w_busy_any | w_stat[p].busy;
            if (w_stat[p].hit) begin
                w_found   = 1'b1;
                w_hit_idx = PAT_IDX_W'(p);
                w_hit_len = w_len[p];
            end
        end
        w_start = r_bytes - OFS_W'(w_hit_len);
        w_done  = w_found || r_last;
    end

    // Handshake and lane commands
    assign o_in_stall = (r_state != T_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_cfg_ok   = i_cfg_we && (i_cfg_idx <= CFG_LENS);
    assign w_finish   = (r_state == T_RUN) && !w_busy_any &&
                        (!r_out_valid || !i_out_stall);

    always_comb begin
        w_cmd.build = (r_state == T_BGO);
        w_cmd.step  = w_in_acc;
        w_cmd.clr   = (w_in_acc && i_start_req) || (w_finish && w_done);
        w_cmd.text  = i_text_byte;
    end

    // Pattern lanes
    for (genvar g = 0; g < NUM_PAT; g++) begin : g_lane
        kmps_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_pattern (r_pat[g]),
            .i_len     (w_len[g]),
            .i_cmd     (w_cmd),
            .o_stat    (w_stat[g])
        );
    end

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lens <= '0;
            for (int p = 0; p < NUM_PAT; p++) begin
                r_pat[p] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_LENS) begin
                r_lens <= i_cfg_wdata[LENS_W-1:0];
            end else if (i_cfg_idx < CFG_LENS) begin
                r_pat[i_cfg_idx[PAT_IDX_W-1:0]] <= i_cfg_wdata[PAT_W-1:0];
            end
        end
    end

    // Sequence word processing and link rebuilds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_bytes <= '0;
            r_last  <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_bytes <= i_start_req ? OFS_W'(1) : r_bytes + OFS_W'(1);
                r_last  <= i_last;
            end else if (w_finish && w_done) begin
                r_bytes <= '0;
            end
            if (w_cfg_ok) begin
                r_state <= T_BGO;
            end else begin
                unique case (r_state)
                    T_IDLE: begin
                        if (w_in_acc) begin
                            r_state <= T_RUN;
                        end
                    end
                    T_BGO: begin
                        r_state <= T_BWAIT;
                    end
                    T_BWAIT: begin
                        if (!w_busy_any) begin
                            r_state <= T_IDLE;
                        end
                    end
                    T_RUN: begin
                        if (w_finish) begin
                            r_state <= T_IDLE;
                        end
                    end
                    default: begin
                        r_state <= T_IDLE;
                    end
                endcase
            end
        end
    end

    // Load and drain the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_done  <= w_done;
            r_out_found <= w_found;
            r_out_idx   <= w_found ? w_hit_idx : '0;
            r_out_start <= w_found ? w_start : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_done_res      = r_out_done;
    assign o_found         = r_out_found;
    assign o_pattern_index = r_out_idx;
    assign o_match_start   = r_out_start;

    // Block is busy right after taking a word or a pattern or length register write
    a_busy_after_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input not stalled after a word was taken");

    a_busy_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_ok |=> o_in_stall)
        else $error("input not stalled during link rebuild");

    a_found_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> o_done_res)
        else $error("match reported without ending the search");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_pattern_index == '0 && o_match_start == '0))
        else $error("index or offset set on a word without a match");

endmodule

### rtl/core/kmps_lane.sv
// One pattern lane: failure-link table, builder and matcher on one byte comparator.
module kmps_lane (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [kmps_pkg::PAT_W-1:0] i_pattern,
    input  kmps_pkg::t_len          i_len,
    input  kmps_pkg::t_lane_cmd     i_cmd,
    output kmps_pkg::t_lane_stat    o_stat
);
    import kmps_pkg::*;

    localparam logic [1:0] L_IDLE  = 2'd0;
    localparam logic [1:0] L_BUILD = 2'd1;
    localparam logic [1:0] L_STEP  = 2'd2;

    logic [1:0]       r_state;
    t_len             r_m;
    t_len             r_k;
    t_len             r_i;
    logic [7:0]       r_c;
    logic             r_hit;
    t_len             r_link [MAX_LEN];

    logic             w_build;
    t_len             w_idx;
    logic [IDX_W-1:0] w_sel;
    logic [IDX_W-1:0] w_prev;
    logic [7:0]       w_a;
    logic [7:0]       w_b;
    logic             w_eq;
    logic             w_walk;
    t_len             w_fb;
    t_len             w_adv;
    t_len             w_m0;

    // Shared comparator: pattern byte at the current prefix against the probe byte
    always_comb begin
        w_build = (r_state == L_BUILD);
        w_idx   = w_build ? r_k : r_m;
        w_sel   = w_idx[IDX_W-1:0];
        w_prev  = w_sel - IDX_W'(1);
        w_a     = i_pattern[{w_sel, 3'b000} +: 8];
        w_b     = w_build ? i_pattern[{r_i[IDX_W-1:0], 3'b000} +: 8] : r_c;
        w_eq    = (w_a == w_b);
        w_walk  = (w_idx != '0) && !w_eq;
        w_fb    = r_link[w_prev];
        w_adv   = w_idx + LEN_W'(w_eq);
        w_m0    = (i_cmd.clr || (r_m >= i_len)) ? '0 : r_m;
    end

    // Sequence link building and per-byte walks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_m     <= '0;
            r_k     <= '0;
            r_i     <= '0;
            r_hit   <= 1'b0;
            for (int j = 0; j < MAX_LEN; j++) begin
                r_link[j] <= '0;
            end
        end else if (i_cmd.build) begin
            r_state <= L_BUILD;
            r_k     <= '0;
            r_i     <= LEN_W'(1);
            r_m     <= '0;
            r_hit   <= 1'b0;
        end else if (i_cmd.step) begin
            r_c     <= i_cmd.text;
            r_hit   <= 1'b0;
            r_m     <= w_m0;
            r_state <= (i_len == '0) ? L_IDLE : L_STEP;
        end else if (i_cmd.clr) begin
            r_m <= '0;
        end else begin
            unique case (r_state)
                L_IDLE: begin
                end
                L_BUILD: begin
                    if (r_i >= i_len) begin
                        r_state <= L_IDLE;
                    end else if (w_walk) begin
                        r_k <= w_fb;
                    end else begin
                        r_k                      <= w_adv;
                        r_link[r_i[IDX_W-1:0]]   <= w_adv;
                        r_i                      <= r_i + LEN_W'(1);
                    end
                end
                L_STEP: begin
                    if (w_walk) begin
                        r_m <= w_fb;
                    end else begin
                        r_m     <= w_adv;
                        r_hit   <= (w_adv == i_len);
                        r_state <= L_IDLE;
                    end
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy = (r_state != L_IDLE);
    assign o_stat.hit  = r_hit;

endmodule
